[hdl/sfp_pkg.sv]
// Shared types, constants and helper functions of the spring force pipeline.
// Used by every module under hdl; depends on nothing else.
package sfp_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_RIGIDITY  = 3'd0;
   localparam logic [2:0] CSR_INT_EXC   = 3'd1;
   localparam logic [2:0] CSR_WORLD     = 3'd2;
   localparam logic [2:0] CSR_DIST_ON   = 3'd3;
   localparam logic [2:0] CSR_MAX_RATIO = 3'd4;
   localparam logic [2:0] CSR_MIN_RATIO = 3'd5;

   localparam logic [16:0] RIGIDITY_ONE = 17'd65536;
   localparam logic [15:0] MAX_RATIO_RST = 16'd512;
   localparam logic [15:0] MIN_RATIO_RST = 16'd128;

   // Square root: 33 root bits, three per stage.
   localparam int SQRT_PAIRS  = 33;
   localparam int SQRT_STEPS  = 3;
   localparam int SQRT_STAGES = (SQRT_PAIRS + SQRT_STEPS - 1) / SQRT_STEPS;

   // Unit vector division: 29 quotient bits, three per stage, after one setup stage.
   localparam int UNIT_BITS  = 28;
   localparam int QUOT_BITS  = UNIT_BITS + 1;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = 1 + (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;

   typedef struct packed {
      logic [16:0] rigidity;
      logic        internals_exception;
      logic        world_spring;
      logic        distance_limit_on;
      logic [15:0] max_ratio;
      logic [15:0] min_ratio;
   } sfp_cfg_type;

   // Per-item control and operands that travel beside the arithmetic.
   typedef struct packed {
      logic        skip;
      logic        imode;
      logic        can_a;
      logic        can_b;
      logic        int_a;
      logic        int_b;
      logic        dx_neg;
      logic        dy_neg;
      logic [31:0] mx;
      logic [31:0] my;
      logic [30:0] rest;
   } sfp_side_type;

   // Signed saturation of a magnitude and sign to 32 bits.
   function automatic logic [31:0] sat32(logic [52:0] mag, logic neg);
      logic [31:0] res;
      if (neg) begin
         if (mag > 53'h0_8000_0000) res = 32'h8000_0000;
         else res = ~mag[31:0] + 32'd1;
      end else begin
         if (mag > 53'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
         else res = mag[31:0];
      end
      return res;
   endfunction

endpackage

[hdl/sfp_front.sv]
// Front end of the spring pipeline: flag decode, endpoint difference, squares
// and their sum. Depends on sfp_pkg.
module sfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [31:0]    a_x,
   input  logic signed [31:0]    a_y,
   input  logic signed [31:0]    b_x,
   input  logic signed [31:0]    b_y,
   input  logic [30:0]           rest_length,
   input  logic                  spring_on,
   input  logic                  spring_internal,
   input  logic [2:0]            a_flags,
   input  logic [2:0]            b_flags,
   input  logic                  both_asleep,
   input  sfp_pkg::sfp_cfg_type  cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [64:0]           out_rad,
   output sfp_pkg::sfp_side_type out_side
);

   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;
   sfp_pkg::sfp_side_type side1_ff, side2_ff, side3_ff, side1_in;
   logic [63:0] sqx_ff, sqy_ff;
   logic [64:0] rad_ff;
   logic signed [32:0] dx, dy;

   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      dx = {b_x[31], b_x} - {a_x[31], a_x};
      dy = {b_y[31], b_y} - {a_y[31], a_y};
      side1_in.dx_neg = dx[32];
      side1_in.dy_neg = dy[32];
      side1_in.mx     = dx[32] ? 32'(-dx) : dx[31:0];
      side1_in.my     = dy[32] ? 32'(-dy) : dy[31:0];
      side1_in.rest   = rest_length;
      side1_in.can_a  = a_flags[0] && !(cfg.world_spring && a_flags[1]);
      side1_in.can_b  = b_flags[0] && !(cfg.world_spring && b_flags[1]);
      side1_in.int_a  = a_flags[2];
      side1_in.int_b  = b_flags[2];
      side1_in.imode  = cfg.internals_exception && spring_internal;
      side1_in.skip   = !spring_on || (cfg.rigidity == 17'd0)
                        || (!side1_in.can_a && !side1_in.can_b) || both_asleep
                        || (side1_in.imode && !a_flags[2] && !b_flags[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) side1_ff <= side1_in;
      if (adv2) begin
         side2_ff <= side1_ff;
         sqx_ff   <= 64'(side1_ff.mx) * 64'(side1_ff.mx);
         sqy_ff   <= 64'(side1_ff.my) * 64'(side1_ff.my);
      end
      if (adv3) begin
         side3_ff <= side2_ff;
         rad_ff   <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      end
   end

   assign out_valid = v3_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side3_ff;

endmodule

[hdl/sfp_sqrt.sv]
// Pipelined digit-by-digit integer square root of the squared distance.
// Depends on sfp_pkg.
module sfp_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [64:0]           in_rad,
   input  sfp_pkg::sfp_side_type in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [32:0]           out_root,
   output sfp_pkg::sfp_side_type out_side
);

   localparam int Stages = sfp_pkg::SQRT_STAGES;
   localparam int Steps  = sfp_pkg::SQRT_STEPS;
   localparam int Pairs  = sfp_pkg::SQRT_PAIRS;

   logic [35:0]           rem_ff  [Stages];
   logic [32:0]           root_ff [Stages];
   logic [65:0]           rad_ff  [Stages];
   sfp_pkg::sfp_side_type side_ff [Stages];
   logic                  v_ff    [Stages];
   logic                  adv     [Stages];

   always_comb begin
      adv[Stages-1] = !v_ff[Stages-1] || out_ready;
      for (int s = Stages - 2; s >= 0; s--) adv[s] = !v_ff[s] || adv[s+1];
   end

   assign in_ready = adv[0];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [35:0]           rem_prev, rem_in;
      logic [32:0]           root_prev, root_in;
      logic [65:0]           rad_prev;
      sfp_pkg::sfp_side_type side_prev;
      logic                  v_prev;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = {1'b0, in_rad};
         assign side_prev = in_side;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign v_prev    = v_ff[s-1];
      end

      // Each step brings down one bit pair and tries the next root bit.
      always_comb begin
         logic [35:0] trial;
         int pidx;
         rem_in  = rem_prev;
         root_in = root_prev;
         for (int j = 0; j < Steps; j++) begin
            pidx = Pairs - 1 - (s * Steps + j);
            if (pidx >= 0) begin
               rem_in = {rem_in[33:0], rad_prev[2*pidx +: 2]};
               trial  = {1'b0, root_in, 2'b01};
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[31:0], 1'b1};
               end else begin
                  root_in = {root_in[31:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (adv[s]) v_ff[s] <= v_prev;
         if (adv[s]) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= rad_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign out_root  = root_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

endmodule

[hdl/sfp_div.sv]
// Pipelined restoring division for both unit vector components, |d| * 2^28 / sl
// rounded to nearest. Depends on sfp_pkg.
module sfp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [32:0]           in_sl,
   input  sfp_pkg::sfp_side_type in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [28:0]           out_ux,
   output logic [28:0]           out_uy,
   output logic [32:0]           out_sl,
   output sfp_pkg::sfp_side_type out_side
);

   localparam int Stages = sfp_pkg::DIV_STAGES;
   localparam int Steps  = sfp_pkg::DIV_STEPS;
   localparam int QBits  = sfp_pkg::QUOT_BITS;
   localparam int UBits  = sfp_pkg::UNIT_BITS;

   logic [32:0]           rem_ff  [Stages][2];
   logic [QBits-1:0]      low_ff  [Stages][2];
   logic [QBits-1:0]      q_ff    [Stages][2];
   logic [32:0]           sl_ff   [Stages];
   sfp_pkg::sfp_side_type side_ff [Stages];
   logic                  v_ff    [Stages];
   logic                  adv     [Stages];

   always_comb begin
      adv[Stages-1] = !v_ff[Stages-1] || out_ready;
      for (int s = Stages - 2; s >= 0; s--) adv[s] = !v_ff[s] || adv[s+1];
   end

   assign in_ready = adv[0];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [32:0]           rem_in [2];
      logic [QBits-1:0]      low_in [2];
      logic [QBits-1:0]      q_in   [2];
      logic [32:0]           sl_prev;
      sfp_pkg::sfp_side_type side_prev;
      logic                  v_prev;

      if (s == 0) begin : g_setup
         assign sl_prev   = in_sl;
         assign side_prev = in_side;
         assign v_prev    = in_valid;
         // Dividend with the rounding half of the divisor already added.
         always_comb begin
            logic [60:0] num [2];
            num[0] = {in_side.mx, UBits'(0)} + 61'(in_sl >> 1);
            num[1] = {in_side.my, UBits'(0)} + 61'(in_sl >> 1);
            for (int l = 0; l < 2; l++) begin
               rem_in[l] = {1'b0, num[l][60:QBits]};
               low_in[l] = num[l][QBits-1:0];
               q_in[l]   = '0;
            end
         end
      end else begin : g_iter
         assign sl_prev   = sl_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign v_prev    = v_ff[s-1];
         always_comb begin
            logic [33:0] part;
            int k;
            for (int l = 0; l < 2; l++) begin
               rem_in[l] = rem_ff[s-1][l];
               low_in[l] = low_ff[s-1][l];
               q_in[l]   = q_ff[s-1][l];
               for (int j = 0; j < Steps; j++) begin
                  k = QBits - 1 - ((s - 1) * Steps + j);
                  if (k >= 0) begin
                     part = {rem_in[l], low_in[l][k]};
                     if (part >= {1'b0, sl_prev}) begin
                        part = part - {1'b0, sl_prev};
                        q_in[l][k] = 1'b1;
                     end
                     rem_in[l] = part[32:0];
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (adv[s]) v_ff[s] <= v_prev;
         if (adv[s]) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[s][l] <= rem_in[l];
               low_ff[s][l] <= low_in[l];
               q_ff[s][l]   <= q_in[l];
            end
            sl_ff[s]   <= sl_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign out_ux    = q_ff[Stages-1][0];
   assign out_uy    = q_ff[Stages-1][1];
   assign out_sl    = sl_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

endmodule

[hdl/sfp_back.sv]
// Back end of the spring pipeline: force magnitude, rigidity scaling, ratio band,
// internal forces, saturation and the result register. Depends on sfp_pkg.
module sfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [28:0]           in_ux,
   input  logic [28:0]           in_uy,
   input  logic [32:0]           in_sl,
   input  sfp_pkg::sfp_side_type in_side,
   input  sfp_pkg::sfp_cfg_type  cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [31:0]    force_a_x,
   output logic signed [31:0]    force_a_y,
   output logic signed [31:0]    force_b_x,
   output logic signed [31:0]    force_b_y,
   output logic                  apply_a,
   output logic                  apply_b,
   output logic                  force_kind
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;
   sfp_pkg::sfp_side_type side1_ff, side2_ff, side3_ff;
   logic [61:0] prx_ff, pry_ff;
   logic [46:0] pmax_ff, pmin_ff;
   logic [32:0] sl1_ff;
   logic        dneg1_ff, dneg2_ff, dneg3_ff;
   logic        slz2_ff, slz3_ff;
   logic [34:0] tx_ff, ty_ff;
   logic [16:0] r_ff;
   logic [51:0] px_ff, py_ff;
   logic [31:0] fax_ff, fay_ff, fbx_ff, fby_ff;
   logic        apa_ff, apb_ff, kind_ff;

   logic signed [33:0] diff;
   logic [32:0]        dm;
   logic [62:0]        rx, ry;
   logic [46:0]        s256;
   logic [16:0]        r_in;
   logic [31:0]        fax_in, fay_in, fbx_in, fby_in;
   logic               apa_in, apb_in, kind_in;

   assign adv4 = !v4_ff || out_ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;

   assign diff = {3'b0, in_side.rest} - {1'b0, in_sl};
   assign dm   = diff[33] ? 33'(-diff) : diff[32:0];

   always_comb begin
      rx   = {1'b0, prx_ff} + (63'd1 << (sfp_pkg::UNIT_BITS - 1));
      ry   = {1'b0, pry_ff} + (63'd1 << (sfp_pkg::UNIT_BITS - 1));
      s256 = {6'b0, sl1_ff, 8'b0};
      r_in = cfg.rigidity;
      if (cfg.distance_limit_on && ((s256 > pmax_ff) || (s256 < pmin_ff)))
         r_in = sfp_pkg::RIGIDITY_ONE;
   end

   // Final rounding, sign and selection between skipped, internal and normal results.
   always_comb begin
      logic [52:0] sx, sy, mgx, mgy, hx, hy;
      logic        fnx, fny;
      hx = '0;
      hy = '0;
      if (side3_ff.can_a && side3_ff.can_b) begin
         sx  = {1'b0, px_ff} + (53'd1 << 16);
         sy  = {1'b0, py_ff} + (53'd1 << 16);
         mgx = sx >> 17;
         mgy = sy >> 17;
      end else begin
         sx  = {1'b0, px_ff} + (53'd1 << 15);
         sy  = {1'b0, py_ff} + (53'd1 << 15);
         mgx = sx >> 16;
         mgy = sy >> 16;
      end
      if (slz3_ff) begin
         mgx = '0;
         mgy = '0;
      end
      fnx = dneg3_ff != side3_ff.dx_neg;
      fny = dneg3_ff != side3_ff.dy_neg;
      fax_in  = '0;
      fay_in  = '0;
      fbx_in  = '0;
      fby_in  = '0;
      apa_in  = 1'b0;
      apb_in  = 1'b0;
      kind_in = 1'b0;
      if (side3_ff.skip) begin
         kind_in = 1'b0;
      end else if (side3_ff.imode) begin
         apa_in  = 1'b1;
         apb_in  = 1'b1;
         kind_in = 1'b1;
         // A quarter each when both ends are internal, otherwise a half for the one.
         if (side3_ff.int_a && side3_ff.int_b) begin
            hx = (53'(side3_ff.mx) + 53'd2) >> 2;
            hy = (53'(side3_ff.my) + 53'd2) >> 2;
         end else begin
            hx = (53'(side3_ff.mx) + 53'd1) >> 1;
            hy = (53'(side3_ff.my) + 53'd1) >> 1;
         end
         if (side3_ff.int_a) begin
            fax_in = sfp_pkg::sat32(hx, side3_ff.dx_neg);
            fay_in = sfp_pkg::sat32(hy, side3_ff.dy_neg);
         end
         if (side3_ff.int_b) begin
            fbx_in = sfp_pkg::sat32(hx, !side3_ff.dx_neg);
            fby_in = sfp_pkg::sat32(hy, !side3_ff.dy_neg);
         end
      end else begin
         apa_in = side3_ff.can_a;
         apb_in = side3_ff.can_b;
         if (side3_ff.can_a) begin
            fax_in = sfp_pkg::sat32(mgx, !fnx);
            fay_in = sfp_pkg::sat32(mgy, !fny);
         end
         if (side3_ff.can_b) begin
            fbx_in = sfp_pkg::sat32(mgx, fnx);
            fby_in = sfp_pkg::sat32(mgy, fny);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
      if (adv1) begin
         side1_ff <= in_side;
         sl1_ff   <= in_sl;
         dneg1_ff <= diff[33];
         prx_ff   <= 62'(dm) * 62'(in_ux);
         pry_ff   <= 62'(dm) * 62'(in_uy);
         pmax_ff  <= 47'(cfg.max_ratio) * 47'(in_side.rest);
         pmin_ff  <= 47'(cfg.min_ratio) * 47'(in_side.rest);
      end
      if (adv2) begin
         side2_ff <= side1_ff;
         dneg2_ff <= dneg1_ff;
         slz2_ff  <= (sl1_ff == 33'd0);
         tx_ff    <= rx[62:sfp_pkg::UNIT_BITS];
         ty_ff    <= ry[62:sfp_pkg::UNIT_BITS];
         r_ff     <= r_in;
      end
      if (adv3) begin
         side3_ff <= side2_ff;
         dneg3_ff <= dneg2_ff;
         slz3_ff  <= slz2_ff;
         px_ff    <= 52'(tx_ff) * 52'(r_ff);
         py_ff    <= 52'(ty_ff) * 52'(r_ff);
      end
      if (adv4) begin
         fax_ff  <= fax_in;
         fay_ff  <= fay_in;
         fbx_ff  <= fbx_in;
         fby_ff  <= fby_in;
         apa_ff  <= apa_in;
         apb_ff  <= apb_in;
         kind_ff <= kind_in;
      end
   end

   assign out_valid  = v4_ff;
   assign force_a_x  = fax_ff;
   assign force_a_y  = fay_ff;
   assign force_b_x  = fbx_ff;
   assign force_b_y  = fby_ff;
   assign apply_a    = apa_ff;
   assign apply_b    = apb_ff;
   assign force_kind = kind_ff;

endmodule

[hdl/spring_force_pair.sv]
// Spring force pair: one 2D mass-spring distance constraint per transfer.
// An accepted request passes 3 front stages, 11 square root stages, 11 division
// stages and 4 back stages; every stage moves on when its successor frees.
// Throughput is one spring per cycle while the response does not stall.
// Synchronous reset empties the pipeline and loads the register defaults.
// Depends on sfp_pkg, sfp_front, sfp_sqrt, sfp_div and sfp_back.
module spring_force_pair (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic [30:0]        req_rest_length,
   input  logic               req_spring_on,
   input  logic               req_spring_internal,
   input  logic [2:0]         req_a_flags,
   input  logic [2:0]         req_b_flags,
   input  logic               req_both_asleep,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_force_a_x,
   output logic signed [31:0] rsp_force_a_y,
   output logic signed [31:0] rsp_force_b_x,
   output logic signed [31:0] rsp_force_b_y,
   output logic               rsp_apply_a,
   output logic               rsp_apply_b,
   output logic               rsp_force_kind,
   // Configuration write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_data
);

   // Configuration registers. Writes are always taken; unknown indexes are dropped.
   sfp_pkg::sfp_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rigidity            <= sfp_pkg::RIGIDITY_ONE;
         cfg_ff.internals_exception <= 1'b0;
         cfg_ff.world_spring        <= 1'b0;
         cfg_ff.distance_limit_on   <= 1'b0;
         cfg_ff.max_ratio           <= sfp_pkg::MAX_RATIO_RST;
         cfg_ff.min_ratio           <= sfp_pkg::MIN_RATIO_RST;
      end else if (csr_valid) begin
         case (csr_index)
            sfp_pkg::CSR_RIGIDITY:  cfg_ff.rigidity            <= csr_data;
            sfp_pkg::CSR_INT_EXC:   cfg_ff.internals_exception <= csr_data[0];
            sfp_pkg::CSR_WORLD:     cfg_ff.world_spring        <= csr_data[0];
            sfp_pkg::CSR_DIST_ON:   cfg_ff.distance_limit_on   <= csr_data[0];
            sfp_pkg::CSR_MAX_RATIO: cfg_ff.max_ratio           <= csr_data[15:0];
            sfp_pkg::CSR_MIN_RATIO: cfg_ff.min_ratio           <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Handshake between sections: each side's ready is the first stage's advance.
   logic                  req_ready;
   logic                  f_valid, f_ready;
   logic [64:0]           f_rad;
   sfp_pkg::sfp_side_type f_side;
   logic                  s_valid, s_ready;
   logic [32:0]           s_root;
   sfp_pkg::sfp_side_type s_side;
   logic                  d_valid, d_ready;
   logic [28:0]           d_ux, d_uy;
   logic [32:0]           d_sl;
   sfp_pkg::sfp_side_type d_side;

   assign req_stall = !req_ready;

   // Flag decode, B minus A and the squared distance.
   sfp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .a_x             (req_a_x),
      .a_y             (req_a_y),
      .b_x             (req_b_x),
      .b_y             (req_b_y),
      .rest_length     (req_rest_length),
      .spring_on       (req_spring_on),
      .spring_internal (req_spring_internal),
      .a_flags         (req_a_flags),
      .b_flags         (req_b_flags),
      .both_asleep     (req_both_asleep),
      .cfg             (cfg_ff),
      .out_valid       (f_valid),
      .out_ready       (f_ready),
      .out_rad         (f_rad),
      .out_side        (f_side)
   );

   // Distance as the floor of the square root, three root bits per stage.
   sfp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_rad    (f_rad),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // Unit vector in Q.28, both axes side by side.
   sfp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_sl     (s_root),
      .in_side   (s_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_ux    (d_ux),
      .out_uy    (d_uy),
      .out_sl    (d_sl),
      .out_side  (d_side)
   );

   // Force scaling and the response register, which holds while the response stalls.
   sfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid),
      .in_ready   (d_ready),
      .in_ux      (d_ux),
      .in_uy      (d_uy),
      .in_sl      (d_sl),
      .in_side    (d_side),
      .cfg        (cfg_ff),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .force_a_x  (rsp_force_a_x),
      .force_a_y  (rsp_force_a_y),
      .force_b_x  (rsp_force_b_x),
      .force_b_y  (rsp_force_b_y),
      .apply_a    (rsp_apply_a),
      .apply_b    (rsp_apply_b),
      .force_kind (rsp_force_kind)
   );

endmodule

[test/spring_force_pair_tb.sv]
// Self-checking testbench for spring_force_pair: spring items with random idling
// are checked field by field against a local predictor of the spring force.
// Depends on sfp_pkg and the spring_force_pair RTL.
module spring_force_pair_tb;

   // Clock, reset and the three channels of the block.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   logic [30:0]        req_rest_length = '0;
   logic               req_spring_on = 1'b0, req_spring_internal = 1'b0;
   logic [2:0]         req_a_flags = '0, req_b_flags = '0;
   logic               req_both_asleep = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_force_a_x, rsp_force_a_y, rsp_force_b_x, rsp_force_b_y;
   logic               rsp_apply_a, rsp_apply_b, rsp_force_kind;

   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [16:0]        csr_data = '0;

   // One spring as sent, and one force result as predicted or observed.
   typedef struct {
      logic [31:0] a_x, a_y, b_x, b_y;
      logic [30:0] rest;
      logic        on, internal;
      logic [2:0]  a_flags, b_flags;
      logic        asleep;
   } spring_type;

   typedef struct {
      logic [31:0] fax, fay, fbx, fby;
      logic        apply_a, apply_b, kind;
   } force_type;

   localparam int PIPE_LATENCY = 29;
   localparam int WATCHDOG_LIMIT = 20000;

   force_type            pending_forces[$];
   sfp_pkg::sfp_cfg_type cfg_shadow;
   int                   mismatch_count = 0;
   int                   idle_cycles = 0;
   bit                   idling_on = 1'b1;

   spring_force_pair u_dut (.*);

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Force predictor. All arithmetic is done on wide unsigned magnitudes
   // with the sign carried apart, so rounding is on the magnitude.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] clamp32(logic [127:0] mag, logic neg);
      if (neg) return (mag >= 128'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
      return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
   endfunction

   function automatic logic [127:0] round_shift(logic [127:0] m, int s);
      return (m + (128'd1 << (s - 1))) >> s;
   endfunction

   function automatic logic [32:0] floor_sqrt(logic [65:0] v);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [32:0] root;
      rem = '0;
      root = '0;
      for (int p = 32; p >= 0; p--) begin
         rem = (rem << 2) | v[2*p +: 2];
         trial = ({35'd0, root} << 2) | 68'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 33'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic force_type predict_force(spring_type s);
      force_type f;
      logic signed [33:0] dx, dy;
      logic [127:0] mx, my, sl, rest, dm, ux, uy, tx, ty, r, mgx, mgy;
      logic can_a, can_b, diff_neg, neg_x, neg_y;
      int sh, sa, sb;
      f = '{default: '0};
      if (!s.on || cfg_shadow.rigidity == 0) return f;
      can_a = s.a_flags[0] && !(cfg_shadow.world_spring && s.a_flags[1]);
      can_b = s.b_flags[0] && !(cfg_shadow.world_spring && s.b_flags[1]);
      if (!can_a && !can_b) return f;
      if (s.asleep) return f;
      dx = $signed({{2{s.b_x[31]}}, s.b_x}) - $signed({{2{s.a_x[31]}}, s.a_x});
      dy = $signed({{2{s.b_y[31]}}, s.b_y}) - $signed({{2{s.a_y[31]}}, s.a_y});
      mx = dx < 0 ? 128'(-dx) : 128'(dx);
      my = dy < 0 ? 128'(-dy) : 128'(dy);
      if (cfg_shadow.internals_exception && s.internal) begin
         // Internal averaging: half weight for a lone internal end, quarter for both.
         if (!s.a_flags[2] && !s.b_flags[2]) return f;
         sa = s.a_flags[2] ? (s.b_flags[2] ? 2 : 1) : 0;
         sb = s.b_flags[2] ? (s.a_flags[2] ? 2 : 1) : 0;
         if (sa != 0) begin
            f.fax = clamp32(round_shift(mx, sa), dx < 0);
            f.fay = clamp32(round_shift(my, sa), dy < 0);
         end
         if (sb != 0) begin
            f.fbx = clamp32(round_shift(mx, sb), dx > 0);
            f.fby = clamp32(round_shift(my, sb), dy > 0);
         end
         f.apply_a = 1'b1;
         f.apply_b = 1'b1;
         f.kind = 1'b1;
         return f;
      end
      sl = 128'(floor_sqrt(66'(mx * mx + my * my)));
      rest = 128'(s.rest);
      r = 128'(cfg_shadow.rigidity);
      sh = (can_a && can_b) ? 17 : 16;
      // Outside the distance ratio band the spring goes fully rigid.
      if (cfg_shadow.distance_limit_on &&
          ((sl << 8) > 128'(cfg_shadow.max_ratio) * rest ||
           (sl << 8) < 128'(cfg_shadow.min_ratio) * rest))
         r = 128'(sfp_pkg::RIGIDITY_ONE);
      mgx = '0;
      mgy = '0;
      neg_x = 1'b0;
      neg_y = 1'b0;
      if (sl != 0) begin
         diff_neg = sl > rest;
         dm = diff_neg ? sl - rest : rest - sl;
         ux = ((mx << sfp_pkg::UNIT_BITS) + sl / 2) / sl;
         uy = ((my << sfp_pkg::UNIT_BITS) + sl / 2) / sl;
         tx = round_shift(dm * ux, sfp_pkg::UNIT_BITS);
         ty = round_shift(dm * uy, sfp_pkg::UNIT_BITS);
         mgx = round_shift(tx * r, sh);
         mgy = round_shift(ty * r, sh);
         neg_x = diff_neg != (dx < 0);
         neg_y = diff_neg != (dy < 0);
      end
      // A zero magnitude has no sign, so both ends read as zero.
      if (mgx == 0) neg_x = 1'b0;
      if (mgy == 0) neg_y = 1'b0;
      if (can_a) begin
         f.fax = clamp32(mgx, !neg_x && mgx != 0);
         f.fay = clamp32(mgy, !neg_y && mgy != 0);
         f.apply_a = 1'b1;
      end
      if (can_b) begin
         f.fbx = clamp32(mgx, neg_x);
         f.fby = clamp32(mgy, neg_y);
         f.apply_b = 1'b1;
      end
      return f;
   endfunction

   // ---------------------------------------------------------------------
   // Shared transfer tasks.
   // ---------------------------------------------------------------------
   // Sends one spring; valid stays high across back-to-back transfers.
   task automatic send_spring(spring_type s);
      req_a_x <= s.a_x;
      req_a_y <= s.a_y;
      req_b_x <= s.b_x;
      req_b_y <= s.b_y;
      req_rest_length <= s.rest;
      req_spring_on <= s.on;
      req_spring_internal <= s.internal;
      req_a_flags <= s.a_flags;
      req_b_flags <= s.b_flags;
      req_both_asleep <= s.asleep;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_forces.push_back(predict_force(s));
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   // Waits until every predicted result has come back, then lets the pipeline empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_forces.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   // Valid stays high between the writes of one configuration sequence.
   task automatic write_csr(logic [2:0] index, logic [16:0] data);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         sfp_pkg::CSR_RIGIDITY:  cfg_shadow.rigidity = data;
         sfp_pkg::CSR_INT_EXC:   cfg_shadow.internals_exception = data[0];
         sfp_pkg::CSR_WORLD:     cfg_shadow.world_spring = data[0];
         sfp_pkg::CSR_DIST_ON:   cfg_shadow.distance_limit_on = data[0];
         sfp_pkg::CSR_MAX_RATIO: cfg_shadow.max_ratio = data[15:0];
         sfp_pkg::CSR_MIN_RATIO: cfg_shadow.min_ratio = data[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(logic [16:0] rig, logic iex, logic world, logic lim,
                             logic [15:0] maxr, logic [15:0] minr);
      write_csr(sfp_pkg::CSR_RIGIDITY, rig);
      write_csr(sfp_pkg::CSR_INT_EXC, 17'(iex));
      write_csr(sfp_pkg::CSR_WORLD, 17'(world));
      write_csr(sfp_pkg::CSR_DIST_ON, 17'(lim));
      write_csr(sfp_pkg::CSR_MAX_RATIO, 17'(maxr));
      write_csr(sfp_pkg::CSR_MIN_RATIO, 17'(minr));
      csr_valid <= 1'b0;
   endtask

   // Random spring. Positions are mostly modest so forces stay in range,
   // with some full-range and corner values to hit saturation.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      endcase
   endfunction

   function automatic spring_type rand_spring();
      spring_type s;
      s.a_x = rand_coord();
      s.a_y = rand_coord();
      s.b_x = ($urandom_range(0, 3) == 0) ? s.a_x : rand_coord();
      s.b_y = ($urandom_range(0, 3) == 0) ? s.a_y : rand_coord();
      case ($urandom_range(0, 5))
         0: s.rest = '0;
         1: s.rest = 31'h7FFF_FFFF;
         2: s.rest = 31'($urandom());
         default: s.rest = 31'($urandom_range(0, 32'h00FF_FFFF));
      endcase
      // Mostly live springs, so the force path is the one exercised.
      s.on = $urandom_range(0, 9) != 0;
      s.internal = 1'($urandom_range(0, 1));
      s.a_flags = 3'($urandom_range(0, 7)) | ($urandom_range(0, 2) != 0 ? 3'b001 : 3'b000);
      s.b_flags = 3'($urandom_range(0, 7)) | ($urandom_range(0, 2) != 0 ? 3'b001 : 3'b000);
      s.asleep = $urandom_range(0, 9) == 0;
      return s;
   endfunction

   function automatic spring_type mk_spring(logic [31:0] ax, ay, bx, by, logic [30:0] rest,
                                            logic [2:0] af, bf, logic internal);
      spring_type s;
      s = '{a_x: ax, a_y: ay, b_x: bx, b_y: by, rest: rest, on: 1'b1,
            internal: internal, a_flags: af, b_flags: bf, asleep: 1'b0};
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stall bursts and a field-by-field check.
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_forces.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response transfer");
         end else begin
            want = pending_forces.pop_front();
            if (rsp_force_a_x !== want.fax || rsp_force_a_y !== want.fay ||
                rsp_force_b_x !== want.fbx || rsp_force_b_y !== want.fby ||
                rsp_apply_a !== want.apply_a || rsp_apply_b !== want.apply_b ||
                rsp_force_kind !== want.kind) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("force mismatch: exp A(%h,%h) B(%h,%h) ap %b%b k %b",
                           want.fax, want.fay, want.fbx, want.fby, want.apply_a,
                           want.apply_b, want.kind);
                  $display("                got A(%h,%h) B(%h,%h) ap %b%b k %b",
                           rsp_force_a_x, rsp_force_a_y, rsp_force_b_x, rsp_force_b_y,
                           rsp_apply_a, rsp_apply_b, rsp_force_kind);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles with no transfer on any channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------
   // Defaults after reset, then the directed corner springs.
   task automatic test_directed();
      set_config(sfp_pkg::RIGIDITY_ONE, 1'b0, 1'b0, 1'b0, sfp_pkg::MAX_RATIO_RST,
                 sfp_pkg::MIN_RATIO_RST);
      send_spring(mk_spring(0, 0, 32'h0003_0000, 32'h0004_0000, 31'h0002_0000,
                            3'b001, 3'b001, 1'b0));
      send_spring(mk_spring(0, 0, 32'h0003_0000, 32'h0004_0000, 31'h0008_0000,
                            3'b001, 3'b000, 1'b0));
      send_spring(mk_spring(0, 0, 32'h0003_0000, 32'h0004_0000, 31'h0008_0000,
                            3'b000, 3'b001, 1'b0));
      // Zero distance gives zero force with apply flags set.
      send_spring(mk_spring(32'h1234, 32'h5678, 32'h1234, 32'h5678, 31'h1_0000,
                            3'b001, 3'b001, 1'b0));
      // Extreme positions saturate the force.
      send_spring(mk_spring(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            31'h0, 3'b001, 3'b001, 1'b0));
      send_spring(mk_spring(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0,
                            31'h7FFF_FFFF, 3'b111, 3'b111, 1'b1));
      // Neither end can respond, asleep, and off.
      send_spring(mk_spring(0, 0, 32'h1_0000, 0, 31'h1_0000, 3'b110, 3'b110, 1'b0));
      begin
         spring_type s;
         s = mk_spring(0, 0, 32'h1_0000, 0, 31'h0, 3'b001, 3'b001, 1'b0);
         s.asleep = 1'b1;
         send_spring(s);
         s.asleep = 1'b0;
         s.on = 1'b0;
         send_spring(s);
      end
      drain();
      // Internal mode with each weight pattern, locked bodies as world springs.
      set_config(sfp_pkg::RIGIDITY_ONE, 1'b1, 1'b1, 1'b1, 16'd256, 16'd256);
      send_spring(mk_spring(0, 0, 32'h0001_0001, 32'hFFFF_0001, 31'h0,
                            3'b101, 3'b001, 1'b1));
      send_spring(mk_spring(0, 0, 32'h0001_0001, 32'hFFFF_0001, 31'h0,
                            3'b001, 3'b101, 1'b1));
      send_spring(mk_spring(0, 0, 32'h0001_0003, 32'hFFFF_0003, 31'h0,
                            3'b101, 3'b111, 1'b1));
      send_spring(mk_spring(0, 0, 32'h0001_0000, 0, 31'h0, 3'b001, 3'b001, 1'b1));
      send_spring(mk_spring(0, 0, 32'h0001_0000, 0, 31'h2_0000, 3'b011, 3'b001, 1'b0));
      send_spring(mk_spring(0, 0, 32'h0001_0000, 0, 31'h0, 3'b001, 3'b001, 1'b0));
      drain();
      // Rigidity zero disables every spring; largest rigidity is used as written.
      set_config(17'd0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'h0000);
      send_spring(mk_spring(0, 0, 32'h5_0000, 0, 31'h1_0000, 3'b001, 3'b001, 1'b0));
      drain();
      set_config(17'h1FFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
      send_spring(mk_spring(0, 0, 32'h5_0000, 32'h1_0000, 31'h1_0000,
                            3'b001, 3'b001, 1'b0));
      send_spring(mk_spring(0, 0, 32'h7FFF_FFFF, 0, 31'h1_0000, 3'b001, 3'b001, 1'b0));
      drain();
   endtask

   // Random springs over a series of register settings.
   task automatic test_random(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         set_config(p % 4 == 0 ? sfp_pkg::RIGIDITY_ONE : 17'($urandom_range(0, 131071)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)),
                    p % 3 == 0 ? 16'hFFFF : 16'($urandom_range(0, 65535)),
                    p % 3 == 1 ? 16'h0000 : 16'($urandom_range(0, 1024)));
         for (int i = 0; i < per_phase; i++) send_spring(rand_spring());
         drain();
      end
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_full_rate();
      idling_on = 1'b0;
      set_config(sfp_pkg::RIGIDITY_ONE, 1'b1, 1'b0, 1'b1, sfp_pkg::MAX_RATIO_RST,
                 sfp_pkg::MIN_RATIO_RST);
      for (int i = 0; i < 300; i++) send_spring(rand_spring());
      drain();
   endtask

   initial begin
      cfg_shadow = '{rigidity: sfp_pkg::RIGIDITY_ONE, internals_exception: 1'b0,
                     world_spring: 1'b0, distance_limit_on: 1'b0,
                     max_ratio: sfp_pkg::MAX_RATIO_RST,
                     min_ratio: sfp_pkg::MIN_RATIO_RST};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(16, 100);
      test_full_rate();
      if (mismatch_count == 0 && pending_forces.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[files.f]
hdl/sfp_pkg.sv
hdl/sfp_front.sv
hdl/sfp_sqrt.sv
hdl/sfp_div.sv
hdl/sfp_back.sv
hdl/spring_force_pair.sv
test/spring_force_pair_tb.sv
